>>> hw/rtl/linear_scan_priority_queue_macros.svh
// Assertion macros shared by the queue's checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH
`define LINEAR_SCAN_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is active
`define LSPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lspq same-cycle check failed");

// Next-cycle implication, disabled while reset is active
`define LSPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lspq next-cycle check failed");

`endif

>>> hw/rtl/lspq_pkg.sv
// Shared types and constants for the linear-scan priority queue.
// No dependencies; imported by the controller, datapath, top level and checker.
package lspq_pkg;

    localparam int PRIO_W   = 8;
    localparam int DATA_W   = 32;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } lspq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_run;
        logic shift_start;
        logic shift_run;
        logic finish;
        logic load_out;
    } lspq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic sweep_done;
        logic out_free;
    } lspq_stat_t;

endpackage

>>> hw/rtl/lspq_ctrl.sv
// Controller state machine for the linear-scan priority queue.
// Depends on lspq_pkg; drives lspq_datapath through lspq_cmd_t.
module lspq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  op,
    input  lspq_pkg::lspq_stat_t  stat,
    output logic                  in_stall,
    output lspq_pkg::lspq_cmd_t   cmd
);
    import lspq_pkg::*;

    lspq_state_t state_reg;
    lspq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == OP_DEQ && !stat.count_zero)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.sweep_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall       = 1'b0;
                cmd.accept     = in_valid;
                cmd.scan_start = in_valid && (op == OP_DEQ) && !stat.count_zero;
            end
            S_SCAN:
            begin
                cmd.scan_run    = 1'b1;
                cmd.shift_start = stat.sweep_done;
            end
            S_SHIFT:
            begin
                cmd.shift_run = 1'b1;
                cmd.finish    = stat.sweep_done;
            end
            S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
        endcase
    end

endmodule

>>> hw/rtl/lspq_datapath.sv
// Datapath of the linear-scan priority queue: entry memory, count, scan and
// shift pointers, best-entry tracking, result and output registers.
// Depends on lspq_pkg; commanded by lspq_ctrl.
module lspq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lspq_pkg::lspq_cmd_t                  cmd,
    output lspq_pkg::lspq_stat_t                 stat,
    input  logic                                 op,
    input  logic        [lspq_pkg::PRIO_W-1:0]   item_priority,
    input  logic signed [lspq_pkg::DATA_W-1:0]   item_data,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic        [lspq_pkg::STATUS_W-1:0] status,
    output logic        [lspq_pkg::PRIO_W-1:0]   out_priority,
    output logic signed [lspq_pkg::DATA_W-1:0]   out_data,
    output logic        [lspq_pkg::FILL_W-1:0]   fill_count
);
    import lspq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ENT_W  = PRIO_W + DATA_W;

    // Entry memory: priority in the upper bits, data below
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              pv_reg;
    logic [ADDR_W-1:0] pidx_reg;

    logic              best_valid_reg;
    logic [ADDR_W-1:0] best_idx_reg;
    logic [PRIO_W-1:0] best_prio_reg;
    logic [DATA_W-1:0] best_data_reg;

    logic [STATUS_W-1:0] res_status_reg;
    logic [PRIO_W-1:0]   res_prio_reg;
    logic [DATA_W-1:0]   res_data_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [FILL_W-1:0]   out_fill_reg;

    logic              count_full;
    logic              enq_ok;
    logic              issue;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ENT_W-1:0]  wr_data;
    logic [PRIO_W-1:0] rd_prio;
    logic [DATA_W-1:0] rd_dat;
    logic [CNT_W+FILL_W-1:0] count_ext;

    // Pointer and port control
    assign count_full = (count_reg == CNT_W'(DEPTH));
    assign enq_ok     = cmd.accept && (op == OP_ENQ) && !count_full;
    assign issue      = (cmd.scan_run || cmd.shift_run) && (idx_reg != count_reg);
    assign rd_addr    = idx_reg[ADDR_W-1:0];
    assign rd_prio    = rd_data_reg[ENT_W-1 -: PRIO_W];
    assign rd_dat     = rd_data_reg[DATA_W-1:0];

    // Write port: append on enqueue, move down one place during the shift sweep
    assign wr_en   = enq_ok || (cmd.shift_run && pv_reg);
    assign wr_addr = cmd.shift_run ? (pidx_reg - ADDR_W'(1)) : count_reg[ADDR_W-1:0];
    assign wr_data = cmd.shift_run ? rd_data_reg : {item_priority, item_data};

    // Memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Count, sweep pointer and read-pipe valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            pv_reg         <= 1'b0;
            best_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (enq_ok)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.finish)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end

            if (cmd.scan_start)
            begin
                idx_reg <= '0;
            end
            else if (cmd.shift_start)
            begin
                idx_reg <= CNT_W'(best_idx_reg) + CNT_W'(1);
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end

            if (cmd.scan_start || cmd.shift_start)
            begin
                pv_reg <= 1'b0;
            end
            else
            begin
                pv_reg <= issue;
            end

            if (cmd.scan_start)
            begin
                best_valid_reg <= 1'b0;
            end
            else if (cmd.scan_run && pv_reg)
            begin
                best_valid_reg <= 1'b1;
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Address of the entry in the read register; best entry so far (strict
    // less-than keeps the earliest entry on a tie)
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pidx_reg <= rd_addr;
        end
        if (cmd.scan_run && pv_reg && (!best_valid_reg || rd_prio < best_prio_reg))
        begin
            best_idx_reg  <= pidx_reg;
            best_prio_reg <= rd_prio;
            best_data_reg <= rd_dat;
        end
    end

    // Pending result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_prio_reg <= '0;
            res_data_reg <= '0;
            if (op == OP_ENQ)
            begin
                res_status_reg <= count_full ? ST_FULL : ST_OK;
            end
            else
            begin
                res_status_reg <= (count_reg == '0) ? ST_EMPTY : ST_OK;
            end
        end
        else if (cmd.finish)
        begin
            res_prio_reg <= best_prio_reg;
            res_data_reg <= best_data_reg;
        end
    end

    // Output register payload
    assign count_ext = (CNT_W + FILL_W)'(count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_prio_reg   <= res_prio_reg;
            out_data_reg   <= res_data_reg;
            out_fill_reg   <= count_ext[FILL_W-1:0];
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.sweep_done = (idx_reg == count_reg) && !pv_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_priority = out_prio_reg;
    assign out_data     = out_data_reg;
    assign fill_count   = out_fill_reg;

endmodule

>>> hw/rtl/linear_scan_priority_queue.sv
// Linear-scan priority queue, DEPTH entries held unsorted in insertion order.
// Enqueue or empty dequeue: result registered, then loaded out when the output is free.
// Dequeue of n stored entries, lowest at index b: a scan of n, then a shift of n - 1 - b
// entries, each at one entry memory read per cycle.
// One item at a time; the next transfer in can be taken in the cycle after the result load.
// Reset clears the count and control state; entries are not cleared.
module linear_scan_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic        [lspq_pkg::PRIO_W-1:0]   item_priority,
    input  logic signed [lspq_pkg::DATA_W-1:0]   item_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic        [lspq_pkg::STATUS_W-1:0] status,
    output logic        [lspq_pkg::PRIO_W-1:0]   out_priority,
    output logic signed [lspq_pkg::DATA_W-1:0]   out_data,
    output logic        [lspq_pkg::FILL_W-1:0]   fill_count
);
    import lspq_pkg::*;

    lspq_cmd_t  cmd;
    lspq_stat_t stat;

    lspq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    lspq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .op            (op),
        .item_priority (item_priority),
        .item_data     (item_data),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .status        (status),
        .out_priority  (out_priority),
        .out_data      (out_data),
        .fill_count    (fill_count)
    );

endmodule

>>> hw/rtl/lspq_checker.sv
// Port-level checker for the linear-scan priority queue, bound to the top level.
// Depends on lspq_pkg and linear_scan_priority_queue_macros.svh.
`include "linear_scan_priority_queue_macros.svh"

module lspq_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic        [lspq_pkg::STATUS_W-1:0] status,
    input logic        [lspq_pkg::PRIO_W-1:0]   out_priority,
    input logic signed [lspq_pkg::DATA_W-1:0]   out_data,
    input logic        [lspq_pkg::FILL_W-1:0]   fill_count
);
    import lspq_pkg::*;

    logic                                     empty_out;
    logic                                     full_out;
    logic                                     zero_payload;
    logic [STATUS_W+PRIO_W+DATA_W+FILL_W-1:0] out_word;

    // Result classification and the full result word
    assign empty_out    = out_valid && (status == ST_EMPTY);
    assign full_out     = out_valid && (status == ST_FULL);
    assign zero_payload = (out_priority == '0) && (out_data == '0);
    assign out_word     = {status, out_priority, out_data, fill_count};

    // Empty dequeue carries no entry and reports an empty queue
    `LSPQ_ASSERT_NOW(a_empty_result, clk, rst_n, empty_out, zero_payload && (fill_count == '0))

    // Refused enqueue carries no entry
    `LSPQ_ASSERT_NOW(a_full_result, clk, rst_n, full_out, zero_payload)

    // Every transfer in keeps the block busy for at least the next cycle
    `LSPQ_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall, in_stall)

    // A stalled result holds
    `LSPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind linear_scan_priority_queue lspq_checker u_lspq_checker (.*);

>>> tb/sv/linear_scan_priority_queue_checker.sv
`timescale 1ns / 1ps
// Checker for the linear-scan priority queue: watches both channels, keeps a shadow queue,
// predicts each result and compares it field by field. Depends on lspq_pkg.
module linear_scan_priority_queue_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_stall,
    input  logic                                 op,
    input  logic        [lspq_pkg::PRIO_W-1:0]   item_priority,
    input  logic signed [lspq_pkg::DATA_W-1:0]   item_data,
    input  logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic        [lspq_pkg::STATUS_W-1:0] status,
    input  logic        [lspq_pkg::PRIO_W-1:0]   out_priority,
    input  logic signed [lspq_pkg::DATA_W-1:0]   out_data,
    input  logic        [lspq_pkg::FILL_W-1:0]   fill_count,
    output int                                   fail_count,
    output int                                   pending,
    output int                                   results_seen,
    output int                                   full_seen,
    output int                                   empty_seen,
    output int                                   served_seen
);
    import lspq_pkg::*;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   prio;
        logic [DATA_W-1:0]   data;
        logic [FILL_W-1:0]   fill;
        logic                served;
    } queue_result_t;

    // Shadow copy of the stored entries, in insertion order
    logic [PRIO_W-1:0] shadow_prio [DEPTH];
    logic [DATA_W-1:0] shadow_data [DEPTH];
    int                shadow_count;

    queue_result_t expected_results [$];

    // Apply one operation to the shadow queue and queue up its result
    task automatic predict_queue_op(input logic op_i, input logic [PRIO_W-1:0] prio_i,
                                    input logic [DATA_W-1:0] data_i);
        queue_result_t r;
        int best;
        r.status = ST_OK;
        r.prio   = '0;
        r.data   = '0;
        r.served = 1'b0;
        if (op_i == OP_ENQ)
        begin
            if (shadow_count >= DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                shadow_prio[shadow_count] = prio_i;
                shadow_data[shadow_count] = data_i;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
        begin
            r.status = ST_EMPTY;
        end
        else
        begin
            // lowest value wins; strict compare keeps the earliest on a tie
            best = 0;
            for (int i = 1; i < shadow_count; i++)
            begin
                if (shadow_prio[i] < shadow_prio[best]) best = i;
            end
            r.prio   = shadow_prio[best];
            r.data   = shadow_data[best];
            r.served = 1'b1;
            for (int i = best + 1; i < shadow_count; i++)
            begin
                shadow_prio[i-1] = shadow_prio[i];
                shadow_data[i-1] = shadow_data[i];
            end
            shadow_count--;
        end
        r.fill = shadow_count[FILL_W-1:0];
        expected_results.push_back(r);
    endtask

    // Sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t e;
        if (!rst_n)
        begin
            shadow_count = 0;
            expected_results.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            full_seen    = 0;
            empty_seen   = 0;
            served_seen  = 0;
        end
        else
        begin
            // result side first: it always belongs to an earlier transfer
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result: status %0d prio %0d data %0d fill %0d",
                                 $realtime, status, out_priority, out_data, fill_count);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.status == ST_FULL) full_seen++;
                    else if (e.status == ST_EMPTY) empty_seen++;
                    else if (e.served) served_seen++;
                    if (status !== e.status || out_priority !== e.prio ||
                        out_data !== e.data || fill_count !== e.fill)
                    begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch: expected status %0d prio %0d data %0d ",
                                      "fill %0d, got status %0d prio %0d data %0d fill %0d"},
                                     $realtime, e.status, e.prio, $signed(e.data), e.fill,
                                     status, out_priority, out_data, fill_count);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_queue_op(op, item_priority, item_data);
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/sv/linear_scan_priority_queue_tb.sv
`timescale 1ns / 1ps
// Top of the priority queue testbench: clock, reset, stimulus, stall pattern and verdict.
// Depends on lspq_pkg, linear_scan_priority_queue and linear_scan_priority_queue_checker.
module linear_scan_priority_queue_tb;

    localparam int DEPTH       = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 100;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic                                 op;
    logic        [lspq_pkg::PRIO_W-1:0]   item_priority;
    logic signed [lspq_pkg::DATA_W-1:0]   item_data;
    logic                                 out_valid;
    logic                                 out_stall;
    logic        [lspq_pkg::STATUS_W-1:0] status;
    logic        [lspq_pkg::PRIO_W-1:0]   out_priority;
    logic signed [lspq_pkg::DATA_W-1:0]   out_data;
    logic        [lspq_pkg::FILL_W-1:0]   fill_count;

    int fail_count;
    int pending;
    int results_seen;
    int full_seen;
    int empty_seen;
    int served_seen;

    bit idle_on;
    int items_sent;
    int quiet_cycles;

    linear_scan_priority_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .item_priority(item_priority),
        .item_data    (item_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_data     (out_data),
        .fill_count   (fill_count)
    );

    linear_scan_priority_queue_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .item_priority(item_priority),
        .item_data    (item_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_priority (out_priority),
        .out_data     (out_data),
        .fill_count   (fill_count),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen),
        .served_seen  (served_seen)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: %0d cycles without a transfer", quiet_cycles);
                $display("linear_scan_priority_queue verification failed");
                $finish;
            end
        end
    end

    // Result side stall bursts of random length
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (!idle_on) begin
                stall_left = 0;
                out_stall  = 1'b0;
            end else begin
                if (stall_left == 0 && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 16);
                out_stall = (stall_left > 0);
                if (stall_left > 0) stall_left--;
            end
        end
    end

    // One transfer on the input channel; returns at the falling edge after it
    task automatic send_item(input logic op_i, input logic [7:0] prio_i,
                             input logic [31:0] data_i);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid      = 1'b1;
        op            = op_i;
        item_priority = prio_i;
        item_data     = data_i;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Priority drawn according to the segment's mode
    function automatic logic [7:0] pick_priority(input int mode);
        case (mode)
            0:       pick_priority = 8'($urandom_range(0, 3));
            1:       pick_priority = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: pick_priority = 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        int enq_pct;
        int prio_mode;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = lspq_pkg::OP_ENQ;
        item_priority = '0;
        item_data     = '0;
        idle_on       = 1'b1;
        items_sent    = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty dequeue, field extremes, tie order
        send_item(lspq_pkg::OP_DEQ, 8'd0,   32'd0);
        send_item(lspq_pkg::OP_ENQ, 8'd255, 32'h7FFF_FFFF);
        send_item(lspq_pkg::OP_ENQ, 8'd0,   32'h8000_0000);
        send_item(lspq_pkg::OP_ENQ, 8'd0,   32'hFFFF_FFFF);
        send_item(lspq_pkg::OP_ENQ, 8'd128, 32'h0000_0000);
        send_item(lspq_pkg::OP_DEQ, 8'hFF,  32'hFFFF_FFFF);
        send_item(lspq_pkg::OP_DEQ, 8'd0,   32'd0);
        // fill up, lowest priority placed in the last slot
        repeat (DEPTH - 3) send_item(lspq_pkg::OP_ENQ, 8'($urandom_range(2, 255)), $urandom);
        send_item(lspq_pkg::OP_ENQ, 8'd1, $urandom);
        // enqueue refused when full, then dequeues with and without shifting
        send_item(lspq_pkg::OP_ENQ, 8'd0, 32'h5A5A_A5A5);
        send_item(lspq_pkg::OP_DEQ, 8'd0, 32'd0);
        send_item(lspq_pkg::OP_DEQ, 8'd0, 32'd0);

        // Random segments, each biased to fill, drain or hover
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg == 0 ? 0 : $urandom_range(0, 2))
                0:       enq_pct = 80;
                1:       enq_pct = 25;
                default: enq_pct = 50;
            endcase
            prio_mode = $urandom_range(0, 2);
            idle_on   = (seg < SEGMENTS - 2) && ($urandom_range(0, 4) != 0);
            for (int k = 0; k < SEG_ITEMS; k++) begin
                if ($urandom_range(1, 100) <= enq_pct)
                    send_item(lspq_pkg::OP_ENQ, pick_priority(prio_mode), $urandom);
                else
                    send_item(lspq_pkg::OP_DEQ, 8'($urandom), $urandom);
            end
        end
        in_valid = 1'b0;

        // Drain and let the block settle
        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);

        $display("covered %0d transfers in and %0d results out: %0d served dequeues,",
                 items_sent, results_seen, served_seen);
        $display("%0d refused enqueues, %0d empty dequeues, %0d still outstanding",
                 full_seen, empty_seen, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("linear_scan_priority_queue verification clean");
        end else begin
            $display("linear_scan_priority_queue verification failed");
        end
        $finish;
    end

endmodule
